>>> rtl/smd_pkg.sv
// Shared types and constants for the sorted merge and deduplication unit.
package smd_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
    localparam logic [OP_W-1:0] OP_MERGE    = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } t_state;

endpackage

>>> rtl/sorted_merge_dedup_unit.sv
// Top level: two list stores, merge sequencer and registered result output.
// Results: an append request gives no result. A merge request moves the sequencer
// into its merge state; results are then loaded into the output register while it
// is free and follow one per cycle while the output is taken.
// Throughput: appends one per cycle while no merge runs; a merge holds the input
// (tready low) until its last result is loaded into the output register.
// Reset: synchronous active low; clears counts, overflow flag, state and output
// valid. Store contents stay undefined until written and are read only below counts.
module sorted_merge_dedup_unit
    import smd_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request side
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // [31:0] value
    input  logic [1:0]        s_axis_tuser,   // [1:0] operation
    // Result side
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [31:0] merged_value
    output logic              m_axis_tlast,   // last
    output logic [1:0]        m_axis_tuser    // [0] empty_res, [1] overflow
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    // Control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt_a, n_cnt_a;
    logic [CW-1:0]   r_cnt_b, n_cnt_b;
    logic [CW-1:0]   r_ia, n_ia;
    logic [CW-1:0]   r_ib, n_ib;
    logic            r_dropped, n_dropped;

    // Output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    logic              r_out_last, n_out_last;
    logic              r_out_empty, n_out_empty;
    logic              r_out_ovf;

    // Store interface
    logic [DATA_W-1:0] a_head, b_head;
    logic              wr_a, wr_b;

    logic in_req;
    logic out_free;
    logic out_load;
    logic a_left, b_left;
    logic take_a, take_b, drop_b;
    logic both_empty;
    logic merge_done;

    assign in_req   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // Appends write at the current fill count; a full list drops the request.
    assign wr_a = in_req && (s_axis_tuser == OP_APPEND_A) && (r_cnt_a < CNT_FULL);
    assign wr_b = in_req && (s_axis_tuser == OP_APPEND_B) && (r_cnt_b < CNT_FULL);

    // Read addresses follow the next head indices so the registered heads line up
    // with r_ia and r_ib.
    smd_ram #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_a),
        .i_wr_addr (r_cnt_a[AW-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_addr (n_ia[AW-1:0]),
        .o_rd_data (a_head)
    );

    smd_ram #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_b),
        .i_wr_addr (r_cnt_b[AW-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_addr (n_ib[AW-1:0]),
        .o_rd_data (b_head)
    );

    // Head compare: smaller head wins, A wins a tie and B's match is dropped.
    assign a_left     = r_ia < r_cnt_a;
    assign b_left     = r_ib < r_cnt_b;
    assign both_empty = (r_cnt_a == '0) && (r_cnt_b == '0);
    assign take_a     = a_left && (!b_left || ($signed(a_head) <= $signed(b_head)));
    assign take_b     = b_left && (!a_left || ($signed(b_head) <  $signed(a_head)));
    assign drop_b     = a_left && b_left && (a_head == b_head);

    // Datapath next values
    always_comb begin
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_dropped   = r_dropped;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_out_data  = r_out_data;
        n_out_last  = 1'b0;
        n_out_empty = 1'b0;
        merge_done  = 1'b0;

        if (r_state == ST_IDLE) begin
            // Hold indices at the list heads, ready for the next merge.
            n_ia = '0;
            n_ib = '0;
            if (in_req) begin
                case (s_axis_tuser)
                    OP_APPEND_A: begin
                        if (wr_a) n_cnt_a = r_cnt_a + 1'b1;
                        else      n_dropped = 1'b1;
                    end
                    OP_APPEND_B: begin
                        if (wr_b) n_cnt_b = r_cnt_b + 1'b1;
                        else      n_dropped = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (out_load) begin
            if (both_empty) begin
                n_out_data  = '0;
                n_out_last  = 1'b1;
                n_out_empty = 1'b1;
                merge_done  = 1'b1;
            end else begin
                // Advance past the emitted head and any dropped match.
                n_out_data = take_a ? a_head : b_head;
                n_ia       = r_ia + CW'(take_a);
                n_ib       = r_ib + CW'(take_b || drop_b);
                n_out_last = (n_ia == r_cnt_a) && (n_ib == r_cnt_b);
                merge_done = n_out_last;
            end
            if (merge_done) begin
                n_cnt_a   = '0;
                n_cnt_b   = '0;
                n_dropped = 1'b0;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_req && (s_axis_tuser == OP_MERGE)) n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (merge_done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_MERGE: out_load      = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt_a   <= n_cnt_a;
            r_cnt_b   <= n_cnt_b;
            r_ia      <= n_ia;
            r_ib      <= n_ib;
            r_dropped <= n_dropped;
            if (out_load)           r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // Result payload; overflow is sampled before the flag clears at the end.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data  <= n_out_data;
            r_out_last  <= n_out_last;
            r_out_empty <= n_out_empty;
            r_out_ovf   <= r_dropped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_ovf, r_out_empty};

    // Head indices never pass the list fill counts during a merge.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |-> ((r_ia <= r_cnt_a) && (r_ib <= r_cnt_b)))
        else $error("merge index beyond list count");

    // Fill counts stay within the store depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_FULL) && (r_cnt_b <= CNT_FULL))
        else $error("list count beyond depth");

    // Loading the final result empties both lists and clears overflow.
    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        merge_done |=> ((r_cnt_a == '0) && (r_cnt_b == '0) && !r_dropped
                        && (r_state == ST_IDLE)))
        else $error("lists not cleared after merge");

    // An empty-merge marker is always the last result of its run.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("empty marker without last");

endmodule

>>> rtl/smd_ram.sv
// Single-port-write, single-port-read list store with registered read data.
module smd_ram
    import smd_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> tb/sorted_merge_dedup_unit_test.sv
// Self-checking testbench for the sorted merge and deduplication unit.
module sorted_merge_dedup_unit_test;
    import smd_pkg::*;

    localparam int LIST_DEPTH = 32;
    localparam int TARGET_REQUESTS = 380;
    localparam int MAX_REPORTS = 10;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
        logic                     is_empty;
        logic                     dropped;
    } t_merge_result;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        bit                has_want;
        t_merge_result     want;
    } t_directed_row;

    localparam t_merge_result NO_RESULT = '0;
    localparam int N_ROWS = 21;

    // Directed requests: empty merges, ignored selector, extremes, matches,
    // repeats within a list, one-sided merges and a single match.
    t_directed_row directed_rows [N_ROWS] = '{
        '{OP_MERGE,    32'h0000_0000, 1'b1, '{32'sd0, 1'b1, 1'b1, 1'b0}},
        '{OP_UNUSED,   32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{OP_MERGE,    32'h0000_0000, 1'b1, '{32'sd0, 1'b1, 1'b1, 1'b0}},
        '{OP_APPEND_A, 32'h8000_0000, 1'b0, NO_RESULT},
        '{OP_APPEND_A, 32'hFFFF_FFFB, 1'b0, NO_RESULT},
        '{OP_APPEND_A, 32'h0000_0007, 1'b0, NO_RESULT},
        '{OP_APPEND_A, 32'h0000_0007, 1'b0, NO_RESULT},
        '{OP_UNUSED,   32'h1234_5678, 1'b0, NO_RESULT},
        '{OP_APPEND_B, 32'hFFFF_FFFB, 1'b0, NO_RESULT},
        '{OP_APPEND_B, 32'h0000_0000, 1'b0, NO_RESULT},
        '{OP_APPEND_B, 32'h7FFF_FFFF, 1'b0, NO_RESULT},
        '{OP_MERGE,    32'hA5A5_A5A5, 1'b0, NO_RESULT},
        '{OP_APPEND_A, 32'h0000_0001, 1'b0, NO_RESULT},
        '{OP_APPEND_A, 32'h0000_0002, 1'b0, NO_RESULT},
        '{OP_MERGE,    32'h0000_0000, 1'b0, NO_RESULT},
        '{OP_APPEND_B, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{OP_APPEND_B, 32'h7FFF_FFFF, 1'b0, NO_RESULT},
        '{OP_MERGE,    32'h0000_0000, 1'b0, NO_RESULT},
        '{OP_APPEND_A, 32'h0000_0003, 1'b0, NO_RESULT},
        '{OP_APPEND_B, 32'h0000_0003, 1'b0, NO_RESULT},
        '{OP_MERGE,    32'hFFFF_FFFF, 1'b1, '{32'sd3, 1'b1, 1'b0, 1'b0}}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata;   // [31:0] value
    logic [1:0]        s_axis_tuser;   // [1:0] operation
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [31:0]       m_axis_tdata;   // [31:0] merged_value
    logic              m_axis_tlast;   // last
    logic [1:0]        m_axis_tuser;   // [0] empty_res, [1] overflow

    sorted_merge_dedup_unit #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the two list stores and the dropped-append flag.
    logic signed [DATA_W-1:0] shadow_list_a [$];
    logic signed [DATA_W-1:0] shadow_list_b [$];
    bit                       shadow_dropped;

    t_merge_result pending_results [$];

    int mismatch_count;
    int checked_results;
    int sent_requests;
    int merge_count;
    int overflow_merges;
    int burst_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 500_000);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("sorted_merge_dedup_unit_test failed");
        $finish;
    end

    // Update the shadow lists for one request and work out the results it gives.
    function automatic void predict_merge_output(input logic [OP_W-1:0] op,
                                                 input logic [DATA_W-1:0] val,
                                                 ref t_merge_result res [$]);
        int ia;
        int ib;
        int na;
        int nb;
        t_merge_result r;
        res.delete();
        ia = 0;
        ib = 0;
        case (op)
            OP_APPEND_A: begin
                if (shadow_list_a.size() < LIST_DEPTH) shadow_list_a.push_back(val);
                else shadow_dropped = 1'b1;
            end
            OP_APPEND_B: begin
                if (shadow_list_b.size() < LIST_DEPTH) shadow_list_b.push_back(val);
                else shadow_dropped = 1'b1;
            end
            OP_MERGE: begin
                na = shadow_list_a.size();
                nb = shadow_list_b.size();
                if (na == 0 && nb == 0) begin
                    r = '{32'sd0, 1'b1, 1'b1, shadow_dropped};
                    res.push_back(r);
                end
                while (ia < na || ib < nb) begin
                    if (ia < na && ib < nb) begin
                        if (shadow_list_a[ia] < shadow_list_b[ib]) begin
                            r.value = shadow_list_a[ia];
                            ia++;
                        end else if (shadow_list_a[ia] > shadow_list_b[ib]) begin
                            r.value = shadow_list_b[ib];
                            ib++;
                        end else begin
                            // equal heads: keep A's element, drop B's
                            r.value = shadow_list_a[ia];
                            ia++;
                            ib++;
                        end
                    end else if (ia < na) begin
                        r.value = shadow_list_a[ia];
                        ia++;
                    end else begin
                        r.value = shadow_list_b[ib];
                        ib++;
                    end
                    r.is_last  = !(ia < na || ib < nb);
                    r.is_empty = 1'b0;
                    r.dropped  = shadow_dropped;
                    res.push_back(r);
                end
                shadow_list_a.delete();
                shadow_list_b.delete();
                shadow_dropped = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Drive one request in bursts with random gaps; predict once it is taken.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                                input bit has_want, input t_merge_result want);
        t_merge_result predicted [$];
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        if (op == OP_MERGE) begin
            merge_count++;
            if (shadow_dropped) overflow_merges++;
        end
        predict_merge_output(op, val, predicted);
        if (has_want) pending_results.push_back(want);
        else foreach (predicted[k]) pending_results.push_back(predicted[k]);
        if (op != OP_UNUSED) sent_requests++;
    endtask

    // Hold the request side idle until every expected result is out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Pick a list length: mostly short, some full, a few past the depth.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return $urandom_range(0, 6);
        if (r < 85) return $urandom_range(7, 20);
        if (r < 93) return LIST_DEPTH;
        return $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
    endfunction

    // Fill an ascending list; a narrow shared window makes matches likely.
    function automatic void fill_sorted(input int n, input int mode, input int base,
                                        input int spread, ref int q [$]);
        int v;
        q.delete();
        repeat (n) begin
            case (mode)
                0: v = base + int'($urandom_range(0, spread));
                1: v = int'($urandom);
                default: begin
                    case ($urandom_range(0, 3))
                        0: v = 32'sh8000_0000 + int'($urandom_range(0, 2));
                        1: v = 32'sh7FFF_FFFF - int'($urandom_range(0, 2));
                        2: v = int'($urandom_range(0, 2)) - 1;
                        default: v = int'($urandom);
                    endcase
                end
            endcase
            q.push_back(v);
        end
        q.sort();
    endfunction

    // Result side: check each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_merge_result got;
        t_merge_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: value=%0d last=%b empty=%b ovf=%b",
                             got.value, got.is_last, got.is_empty, got.dropped);
            end else begin
                want = pending_results.pop_front();
                checked_results++;
                if (got.value !== want.value || got.is_last !== want.is_last ||
                    got.is_empty !== want.is_empty || got.dropped !== want.dropped) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: want value=%0d last=%b empty=%b ovf=%b, ",
                                  "got value=%0d last=%b empty=%b ovf=%b"},
                                 want.value, want.is_last, want.is_empty, want.dropped,
                                 got.value, got.is_last, got.is_empty, got.dropped);
                end
            end
        end
    end

    // Result side stalls: switch between stall densities every so often.
    initial begin
        int mode;
        int hold;
        m_axis_tready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            hold = $urandom_range(20, 150);
            repeat (hold) begin
                @(posedge i_clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial begin
        int list_a [$];
        int list_b [$];
        int ia;
        int ib;
        int mode;
        int base;
        int spread;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_APPEND_A;
        i_rst_n       <= 1'b0;
        mismatch_count  = 0;
        checked_results = 0;
        sent_requests   = 0;
        merge_count     = 0;
        overflow_merges = 0;
        burst_left      = 0;
        shadow_dropped  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_request(directed_rows[k].op, directed_rows[k].value,
                         directed_rows[k].has_want, directed_rows[k].want);
        drain_results();

        while (sent_requests < TARGET_REQUESTS) begin
            if ($urandom_range(0, 99) < 85) begin
                // well-formed load of two ascending lists, then merge
                mode   = $urandom_range(0, 2);
                spread = $urandom_range(0, 3) == 0 ? 3 : $urandom_range(4, 60);
                base   = int'($urandom);
                if (base > 32'sh7FFF_FFFF - spread) base = 32'sh7FFF_FFFF - spread;
                fill_sorted(pick_length(), mode, base, spread, list_a);
                fill_sorted(pick_length(), mode, base, spread, list_b);
                ia = 0;
                ib = 0;
                while (ia < list_a.size() || ib < list_b.size()) begin
                    if ($urandom_range(0, 19) == 0)
                        send_request(OP_UNUSED, $urandom, 1'b0, NO_RESULT);
                    if (ib >= list_b.size() ||
                        (ia < list_a.size() && $urandom_range(0, 1) == 1)) begin
                        send_request(OP_APPEND_A, list_a[ia], 1'b0, NO_RESULT);
                        ia++;
                    end else begin
                        send_request(OP_APPEND_B, list_b[ib], 1'b0, NO_RESULT);
                        ib++;
                    end
                end
                send_request(OP_MERGE, $urandom, 1'b0, NO_RESULT);
            end else begin
                // unordered noise, merged only some of the time
                repeat ($urandom_range(1, 10))
                    send_request(2'($urandom_range(0, 3)), $urandom, 1'b0, NO_RESULT);
                if ($urandom_range(0, 1) == 1)
                    send_request(OP_MERGE, $urandom, 1'b0, NO_RESULT);
            end
            if ($urandom_range(0, 9) == 0) drain_results();
        end

        send_request(OP_MERGE, $urandom, 1'b0, NO_RESULT);
        drain_results();
        repeat (20) @(posedge i_clk);

        $display("covered %0d requests, %0d merges (%0d with dropped appends)",
                 sent_requests, merge_count, overflow_merges);
        $display("checked %0d merge results, %0d mismatches", checked_results,
                 mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("sorted_merge_dedup_unit_test passed");
        end else begin
            $display("sorted_merge_dedup_unit_test failed");
        end
        $finish;
    end

endmodule
